/* rtl/spt_pkg.sv */
// Shared types and constants for the sorted page table with a lazy tail.
// Used by the storage cells and the top-level sequencer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int PAGES_W   = 32;
    localparam int SUM_W     = 48;
    localparam int POS_W     = 11;
    localparam int TAIL_SCAN_LIMIT = 7;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_INS   = 3'd1,
        CELL_WRITE = 3'd2,
        CELL_DEL   = 3'd3,
        CELL_SORT  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic                 phase;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/spt_cell.sv */
// One table position: holds an entry and trades it with its two neighbors.
// Depends on spt_pkg for the entry and command types.
`timescale 1ns / 1ps
`default_nettype none

module spt_cell
    import spt_pkg::*;
#(
    parameter int IDX = 1,
    parameter int CW  = 12
)
(
    input  wire logic          clk,
    input  wire cell_cmd_t     cmd,
    input  wire logic [CW-1:0] sorted,
    input  wire logic [CW-1:0] len,
    input  wire logic [CW-1:0] pos,
    input  wire entry_t        left,
    input  wire entry_t        right,
    input  wire logic          left_shift,
    output logic               shift,
    output entry_t             value
);

    localparam logic [CW-1:0] MY_POS = CW'(IDX);
    localparam logic          MY_PAR = 1'(IDX % 2);

    entry_t value_reg;
    entry_t value_next;
    logic   pair_left;
    logic   pair_right;

    // During an insert, every tail cell and every head cell with a larger key moves up.
    assign shift = (MY_POS > sorted) || (value_reg.key > cmd.key);
    assign value = value_reg;

    // Odd-even transposition: pairs (j, j+1) with j of the current parity compare.
    assign pair_left  = (MY_PAR == cmd.phase) && (MY_POS < len)
                        && (value_reg.key > right.key);
    assign pair_right = (MY_PAR != cmd.phase) && (IDX >= 2) && (MY_POS <= len)
                        && (left.key > value_reg.key);

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (shift)
                begin
                    value_next = left_shift ? left : '{key: cmd.key, payload: cmd.payload};
                end
            end
            CELL_WRITE:
            begin
                if (MY_POS == pos)
                begin
                    value_next = '{key: cmd.key, payload: cmd.payload};
                end
            end
            CELL_DEL:
            begin
                if (MY_POS >= pos)
                begin
                    value_next = right;
                end
            end
            CELL_SORT:
            begin
                if (pair_left)
                begin
                    value_next = right;
                end
                else if (pair_right)
                begin
                    value_next = left;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

/* rtl/sorted_page_table_lazy_tail.sv */
// Flow: clear and rejected words go straight to the done state; a remove shifts later entries down;
// an append inserts in order, writes at the tail or first reads a pivot entry to choose; a search
// scans the tail entries, then bisects the head, sorting the whole table first if the tail is too long.
// A word is accepted only when idle; a finished word waits in the output register until taken.
// The sort is odd-even transposition over the cell row, one pass per cycle.
// Reset (rst_n low, asynchronous) empties the table; entry storage is not cleared.
// Top level: sequencer, read port and the row of storage cells. Depends on spt_pkg, spt_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_page_table_lazy_tail
    import spt_pkg::*;
#(
    parameter int CAPACITY        = 1024,
    parameter int INSERT_DISTANCE = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,  // key, page_count, payload, position
    input  wire logic [1:0]   s_tuser,  // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata   // status, found_position, found_key,
                                        // found_payload, entry_count, page_total
);

    localparam int CL = $clog2(CAPACITY + 2);
    localparam int CW = (CL > 12) ? CL : 12;
    localparam int AW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW:0]   DIST_C = (CW+1)'(INSERT_DISTANCE);
    localparam logic [CW-1:0] LIMIT_C = CW'(TAIL_SCAN_LIMIT);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_PIV   = 12'b000000000010,
        ST_INS   = 12'b000000000100,
        ST_APP   = 12'b000000001000,
        ST_DEL   = 12'b000000010000,
        ST_SORT  = 12'b000000100000,
        ST_SCHK  = 12'b000001000000,
        ST_SCAN  = 12'b000010000000,
        ST_BCHK  = 12'b000100000000,
        ST_BIS   = 12'b001000000000,
        ST_FETCH = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         len_reg;
    logic [CW-1:0]         sorted_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [PAYLOAD_W-1:0]  pay_reg;
    logic [PAGES_W-1:0]    count_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         rd_addr_reg;
    logic                  rd_wait_reg;
    entry_t                rd_reg;
    logic [CW-1:0]         lo_reg;
    logic [CW-1:0]         hi_reg;
    logic [CW-1:0]         scan_reg;
    logic [CW-1:0]         pass_reg;
    logic                  phase_reg;
    logic [1:0]            status_reg;
    logic [CW-1:0]         fpos_reg;
    logic [KEY_W-1:0]      fkey_reg;
    logic [PAYLOAD_W-1:0]  fpay_reg;
    logic                  m_tvalid_reg;
    logic [167:0]          m_tdata_reg;

    cell_cmd_t     cmd;
    logic [CW-1:0] cell_pos;
    logic [CW-1:0] mid;
    logic [CW-1:0] in_pos;
    entry_t        cell_q [0:CAPACITY+1];
    logic          shift_q [0:CAPACITY];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_pos   = CW'(s_tdata[138:128]);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        cmd.op      = CELL_HOLD;
        cmd.phase   = phase_reg;
        cmd.key     = key_reg;
        cmd.payload = pay_reg;
        case (state_reg)
            ST_INS:  cmd.op = CELL_INS;
            ST_APP:  cmd.op = CELL_WRITE;
            ST_DEL:  cmd.op = CELL_DEL;
            ST_SORT: cmd.op = (pass_reg != '0) ? CELL_SORT : CELL_HOLD;
            default: cmd.op = CELL_HOLD;
        endcase
        cell_pos = (state_reg == ST_APP) ? (len_reg + CW'(1)) : pos_reg;
    end

    // The row of cells; the ends see an empty neighbor.
    assign cell_q[0]           = '0;
    assign cell_q[CAPACITY+1]  = '0;
    assign shift_q[0]          = 1'b0;

    for (genvar g = 1; g <= CAPACITY; g++)
    begin : g_cell
        spt_cell #(.IDX(g), .CW(CW)) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .sorted     (sorted_reg),
            .len        (len_reg),
            .pos        (cell_pos),
            .left       (cell_q[g-1]),
            .right      (cell_q[g+1]),
            .left_shift (shift_q[g-1]),
            .shift      (shift_q[g]),
            .value      (cell_q[g])
        );
    end

    // Registered read port over the row.
    always_ff @(posedge clk)
    begin
        rd_reg <= cell_q[rd_addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            sorted_reg   <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            rd_wait_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        key_reg    <= s_tdata[31:0];
                        count_reg  <= s_tdata[63:32];
                        pay_reg    <= s_tdata[127:64];
                        pos_reg    <= in_pos;
                        status_reg <= (s_tuser == KIND_APPEND && len_reg >= CAP_C)
                                      ? STATUS_FULL
                                      : (s_tuser == KIND_REMOVE
                                         && (in_pos == '0 || in_pos > len_reg))
                                      ? STATUS_RANGE : STATUS_OK;
                        fpos_reg   <= '0;
                        fkey_reg   <= '0;
                        fpay_reg   <= '0;
                        lo_reg     <= CW'(1);
                        hi_reg     <= sorted_reg + CW'(1);
                        case (s_tuser)
                            KIND_APPEND:
                            begin
                                if (len_reg >= CAP_C)
                                begin
                                    state_reg  <= ST_DONE;
                                end
                                else if ({1'b0, len_reg} <= DIST_C)
                                begin
                                    state_reg <= ST_INS;
                                end
                                else if ({1'b0, len_reg} > {1'b0, sorted_reg} + DIST_C)
                                begin
                                    state_reg <= ST_APP;
                                end
                                else
                                begin
                                    rd_addr_reg <= len_reg - DIST_C[CW-1:0];
                                    rd_wait_reg <= 1'b1;
                                    state_reg   <= ST_PIV;
                                end
                            end
                            KIND_SEARCH:
                            begin
                                if ((len_reg - sorted_reg) > LIMIT_C)
                                begin
                                    pass_reg  <= len_reg;
                                    phase_reg <= 1'b0;
                                    state_reg <= ST_SORT;
                                end
                                else
                                begin
                                    scan_reg  <= sorted_reg + CW'(1);
                                    state_reg <= ST_SCHK;
                                end
                            end
                            KIND_REMOVE:
                            begin
                                state_reg <= (in_pos == '0 || in_pos > len_reg) ? ST_DONE
                                                                                 : ST_DEL;
                            end
                            KIND_CLEAR:
                            begin
                                len_reg    <= '0;
                                sorted_reg <= '0;
                                sum_reg    <= '0;
                                state_reg  <= ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_PIV:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= (rd_reg.key < key_reg) ? ST_INS : ST_APP;
                    end
                end
                ST_INS:
                begin
                    len_reg    <= len_reg + CW'(1);
                    sorted_reg <= sorted_reg + CW'(1);
                    sum_reg    <= sum_reg + SUM_W'(count_reg);
                    state_reg  <= ST_DONE;
                end
                ST_APP:
                begin
                    len_reg   <= len_reg + CW'(1);
                    sum_reg   <= sum_reg + SUM_W'(count_reg);
                    state_reg <= ST_DONE;
                end
                ST_DEL:
                begin
                    sum_reg <= sum_reg - SUM_W'(count_reg);
                    if (sorted_reg >= pos_reg)
                    begin
                        sorted_reg <= sorted_reg - CW'(1);
                    end
                    len_reg   <= len_reg - CW'(1);
                    state_reg <= ST_DONE;
                end
                ST_SORT:
                begin
                    if (pass_reg == '0)
                    begin
                        sorted_reg <= len_reg;
                        hi_reg     <= len_reg + CW'(1);
                        state_reg  <= ST_BCHK;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg - CW'(1);
                        phase_reg <= ~phase_reg;
                    end
                end
                ST_SCHK:
                begin
                    if (scan_reg <= len_reg)
                    begin
                        rd_addr_reg <= scan_reg;
                        rd_wait_reg <= 1'b1;
                        state_reg   <= ST_SCAN;
                    end
                    else
                    begin
                        state_reg <= ST_BCHK;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else if (rd_reg.key == key_reg)
                    begin
                        fpos_reg  <= scan_reg;
                        fkey_reg  <= rd_reg.key;
                        fpay_reg  <= rd_reg.payload;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + CW'(1);
                        state_reg <= ST_SCHK;
                    end
                end
                ST_BCHK:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        rd_addr_reg <= mid;
                        rd_wait_reg <= 1'b1;
                        state_reg   <= ST_BIS;
                    end
                    else
                    begin
                        fpos_reg <= lo_reg;
                        if (lo_reg <= len_reg)
                        begin
                            rd_addr_reg <= lo_reg;
                            rd_wait_reg <= 1'b1;
                            state_reg   <= ST_FETCH;
                        end
                        else
                        begin
                            fkey_reg  <= '1;
                            fpay_reg  <= '0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_BIS:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        if (rd_reg.key < key_reg)
                        begin
                            lo_reg <= mid + CW'(1);
                        end
                        else
                        begin
                            hi_reg <= mid;
                        end
                        state_reg <= ST_BCHK;
                    end
                end
                ST_FETCH:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        fkey_reg  <= rd_reg.key;
                        fpay_reg  <= rd_reg.payload;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {sum_reg, len_reg[POS_W-1:0], fpay_reg, fkey_reg,
                            fpos_reg[POS_W-1:0], status_reg};
        end
    end

    a_sorted_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_reg <= len_reg)
        else $error("head longer than table");

    a_len_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP_C)
        else $error("table length beyond capacity");

    a_sort_all_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT && pass_reg == '0) |=> (sorted_reg == len_reg))
        else $error("sort did not make the whole table head");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("finished word not presented");

endmodule

`default_nettype wire
